// ----- src/pidcs_pkg.sv -----
// Shared constants, types and clamp helper for the PID step unit.
package pidcs_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int DATA_W      = 16;
    localparam int ERR_W       = DATA_W + 1;
    localparam int INTEG_W     = DATA_W + FRAC_BITS;
    localparam int PROD_W      = DATA_W + ERR_W;
    localparam int WIDE_W      = PROD_W + 2;
    localparam int TIME_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = DATA_W + TIME_W;
    localparam int OUT_TDATA_W = DATA_W;
    localparam int OUT_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd7;

    typedef logic signed [DATA_W-1:0]  sample_t;
    typedef logic signed [ERR_W-1:0]   error_t;
    typedef logic signed [INTEG_W-1:0] integ_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    // Crossed limits: upper if x is above it, else lower.
    function automatic wide_t clamp_wide(input wide_t x, input wide_t lo, input wide_t hi);
        wide_t r;
        if (x > hi)
        begin
            r = hi;
        end
        else if (x < lo)
        begin
            r = lo;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

endpackage

// ----- src/pid_controller_step_unit.sv -----
// PID step unit: derivative on measurement, fixed point, one word per cycle while m_tready does not stall the output.
//
// Input stream s_*: each word is a sample (s_tuser = 0) carrying a measurement
// and a millisecond timestamp, or a bumpless reinitialize (s_tuser = 1).
// Output stream m_*: exactly one word per input word, in order, carrying the
// drive and two flags (update computed, error inside deadband).
// Configuration: cfg_we with cfg_index / cfg_data writes one of eight 16-bit
// registers; write only while no word is in flight.
// Path: a word accepted on s_* passes the input register, then the result register,
// two registers in all, before it shows on m_tvalid.
// Throughput: one word per cycle while m_tready does not stall the output; the state
// update of one word is done combinationally between the two registers, so the next
// word follows at once.
// Stall: while m_tready is low the result register holds; one more word can
// wait in the input register, then s_tready drops.
// Reset: both streams empty, all controller state zero, registers at their defaults
// (limits at full range, period 100 ms); the stream data registers are not reset.
module pid_controller_step_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pidcs_pkg::IN_TDATA_W-1:0]    s_tdata,   // measurement, time_ms
    input  logic                                s_tuser,   // command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pidcs_pkg::OUT_TDATA_W-1:0]   m_tdata,   // drive
    output logic [pidcs_pkg::OUT_TUSER_W-1:0]   m_tuser,   // updated, in_deadband
    input  logic                                cfg_we,
    input  logic [pidcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pidcs_pkg::DATA_W-1:0]        cfg_data
);
    import pidcs_pkg::*;

    sample_t                target_reg, kp_reg, ki_reg, kd_reg, min_reg, max_reg;
    logic [DATA_W-1:0]      period_reg, deadband_reg;

    sample_t                latest_reg, latest_next;
    sample_t                prior_reg, prior_next;
    logic [TIME_W-1:0]      last_time_reg, last_time_next;
    integ_t                 integ_reg, integ_next;
    sample_t                held_reg, held_next;
    error_t                 last_err_reg, last_err_next;

    logic                   in_valid_reg;
    logic                   cmd_reg;
    sample_t                meas_reg;
    logic [TIME_W-1:0]      time_reg;

    logic                   out_valid_reg;
    sample_t                drive_reg, drive_next;
    logic                   updated_reg, updated_next;
    logic                   dead_reg, dead_next;

    logic                   out_free;
    logic                   advance;
    logic                   do_update;
    logic [TIME_W-1:0]      elapsed;
    error_t                 err, din;
    prod_t                  p_prod, i_prod, d_prod;
    wide_t                  lo_w, hi_w, lo_s, hi_s;
    wide_t                  integ_raw, sum_raw, sum_shift;
    integ_t                 integ_upd, integ_reinit;
    sample_t                drive_upd;
    logic [ERR_W-1:0]       err_mag;

    sample_t                cfg_lo, cfg_hi;
    wide_t                  cfg_lo_w, cfg_hi_w;
    sample_t                held_cfg;
    integ_t                 integ_cfg;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = {dead_reg, updated_reg};

    always_comb
    begin
        lo_w      = WIDE_W'(min_reg);
        hi_w      = WIDE_W'(max_reg);
        lo_s      = lo_w <<< FRAC_BITS;
        hi_s      = hi_w <<< FRAC_BITS;

        elapsed   = time_reg - last_time_reg;
        do_update = !cmd_reg && (elapsed >= TIME_W'(period_reg));

        err       = ERR_W'(target_reg) - ERR_W'(meas_reg);
        din       = ERR_W'(meas_reg) - ERR_W'(prior_reg);
        p_prod    = PROD_W'(kp_reg) * PROD_W'(err);
        i_prod    = PROD_W'(ki_reg) * PROD_W'(err);
        d_prod    = PROD_W'(kd_reg) * PROD_W'(din);

        integ_raw = WIDE_W'(integ_reg) + WIDE_W'(i_prod);
        integ_upd = INTEG_W'(clamp_wide(integ_raw, lo_s, hi_s));
        sum_raw   = WIDE_W'(p_prod) + WIDE_W'(integ_upd) - WIDE_W'(d_prod);
        sum_shift = sum_raw >>> FRAC_BITS;
        drive_upd = DATA_W'(clamp_wide(sum_shift, lo_w, hi_w));

        integ_reinit = INTEG_W'(clamp_wide(WIDE_W'(held_reg) <<< FRAC_BITS, lo_s, hi_s));

        latest_next    = latest_reg;
        prior_next     = prior_reg;
        last_time_next = last_time_reg;
        integ_next     = integ_reg;
        held_next      = held_reg;
        last_err_next  = last_err_reg;
        updated_next   = 1'b0;

        if (cmd_reg)
        begin
            prior_next = latest_reg;
            integ_next = integ_reinit;
        end
        else
        begin
            latest_next = meas_reg;
            if (do_update)
            begin
                integ_next     = integ_upd;
                held_next      = drive_upd;
                last_err_next  = err;
                prior_next     = meas_reg;
                last_time_next = time_reg;
                updated_next   = 1'b1;
            end
        end

        err_mag    = last_err_next[ERR_W-1] ? ERR_W'(-last_err_next) : ERR_W'(last_err_next);
        dead_next  = err_mag < ERR_W'(deadband_reg);
        drive_next = dead_next ? '0 : held_next;
    end

    // Re-clamp held drive and integral against the limits being written.
    always_comb
    begin
        cfg_lo    = (cfg_index == REG_MIN) ? sample_t'(cfg_data) : min_reg;
        cfg_hi    = (cfg_index == REG_MAX) ? sample_t'(cfg_data) : max_reg;
        cfg_lo_w  = WIDE_W'(cfg_lo);
        cfg_hi_w  = WIDE_W'(cfg_hi);
        held_cfg  = DATA_W'(clamp_wide(WIDE_W'(held_reg), cfg_lo_w, cfg_hi_w));
        integ_cfg = INTEG_W'(clamp_wide(WIDE_W'(integ_reg),
                                        cfg_lo_w <<< FRAC_BITS, cfg_hi_w <<< FRAC_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            min_reg      <= {1'b1, {(DATA_W-1){1'b0}}};
            max_reg      <= {1'b0, {(DATA_W-1){1'b1}}};
            period_reg   <= DATA_W'(100);
            deadband_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET:   target_reg   <= cfg_data;
                REG_KP:       kp_reg       <= cfg_data;
                REG_KI:       ki_reg       <= cfg_data;
                REG_KD:       kd_reg       <= cfg_data;
                REG_MIN:      min_reg      <= cfg_data;
                REG_MAX:      max_reg      <= cfg_data;
                REG_PERIOD:   period_reg   <= cfg_data;
                REG_DEADBAND: deadband_reg <= cfg_data;
                default:      target_reg   <= target_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg    <= '0;
            prior_reg     <= '0;
            last_time_reg <= '0;
            integ_reg     <= '0;
            held_reg      <= '0;
            last_err_reg  <= '0;
        end
        else if (advance)
        begin
            latest_reg    <= latest_next;
            prior_reg     <= prior_next;
            last_time_reg <= last_time_next;
            integ_reg     <= integ_next;
            held_reg      <= held_next;
            last_err_reg  <= last_err_next;
        end
        else if (cfg_we && (cfg_index == REG_MIN || cfg_index == REG_MAX))
        begin
            held_reg  <= held_cfg;
            integ_reg <= integ_cfg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg  <= s_tuser;
            meas_reg <= s_tdata[DATA_W-1:0];
            time_reg <= s_tdata[IN_TDATA_W-1:DATA_W];
        end
        if (advance)
        begin
            drive_reg   <= drive_next;
            updated_reg <= updated_next;
            dead_reg    <= dead_next;
        end
    end

endmodule

// ----- src/pidcs_checker.sv -----
// Port-level checker for the PID step unit, with its bind statement.
module pidcs_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [pidcs_pkg::OUT_TDATA_W-1:0]   m_tdata,   // drive
    input  logic [pidcs_pkg::OUT_TUSER_W-1:0]   m_tuser    // updated, in_deadband
);
    import pidcs_pkg::*;

    logic [1:0] pending_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_fire) - 2'(out_fire);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == '0)
        else $error("drive not zero inside deadband");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd0 |-> !m_tvalid)
        else $error("output word without pending input word");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3 && !(pending_reg == 2'd2 && !m_tready && s_tready))
        else $error("more than two words in flight");

endmodule

bind pid_controller_step_unit pidcs_checker u_pidcs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- sim/pid_controller_step_unit_test.sv -----
// Self-checking stream test of the PID step unit against a cycle-free drive predictor.
`timescale 1ns / 100ps

module pid_controller_step_unit_test;

    import pidcs_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 244;
    localparam int LONG_HOLD     = 400;

    typedef struct packed {
        sample_t drive;
        logic    updated;
        logic    in_deadband;
    } drive_word_t;

    class pid_drive_predictor;
        sample_t     target_value = '0;
        sample_t     prop_gain    = '0;
        sample_t     integ_gain   = '0;
        sample_t     deriv_gain   = '0;
        sample_t     drive_min    = 16'sh8000;
        sample_t     drive_max    = 16'sh7fff;
        logic [15:0] period_ms    = 16'd100;
        logic [15:0] deadband     = 16'd0;
        sample_t     latest_meas  = '0;
        sample_t     prior_meas   = '0;
        logic [31:0] last_time    = '0;
        longint      integral     = 0;
        longint      held_drive   = 0;
        longint      last_error   = 0;
        drive_word_t expected_drives[$];
        int          mismatches   = 0;

        function longint clamp_to(longint x, longint lo, longint hi);
            if (x > hi)
            begin
                return hi;
            end
            if (x < lo)
            begin
                return lo;
            end
            return x;
        endfunction

        function longint widen(longint v);
            return v * (longint'(1) << FRAC_BITS);
        endfunction

        function longint clamp_integral(longint x);
            return clamp_to(x, widen(longint'(drive_min)), widen(longint'(drive_max)));
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_TARGET:   target_value = value;
                REG_KP:       prop_gain = value;
                REG_KI:       integ_gain = value;
                REG_KD:       deriv_gain = value;
                REG_MIN:      drive_min = value;
                REG_MAX:      drive_max = value;
                REG_PERIOD:   period_ms = value;
                REG_DEADBAND: deadband = value;
                default:      ;
            endcase
            if (idx == REG_MIN || idx == REG_MAX)
            begin
                held_drive = clamp_to(held_drive, longint'(drive_min), longint'(drive_max));
                integral   = clamp_integral(integral);
            end
        endfunction

        function void take_word(logic cmd, sample_t meas, logic [31:0] now);
            longint      err;
            longint      delta;
            longint      sum;
            longint      mag;
            logic [31:0] elapsed;
            drive_word_t w;
            w.updated = 1'b0;
            if (cmd)
            begin
                prior_meas = latest_meas;
                integral   = clamp_integral(widen(held_drive));
            end
            else
            begin
                latest_meas = meas;
                elapsed = now - last_time;
                if (elapsed >= {16'd0, period_ms})
                begin
                    err      = longint'(target_value) - longint'(meas);
                    delta    = longint'(meas) - longint'(prior_meas);
                    integral = clamp_integral(integral + longint'(integ_gain) * err);
                    sum = longint'(prop_gain) * err + integral - longint'(deriv_gain) * delta;
                    held_drive = clamp_to(sum >>> FRAC_BITS, longint'(drive_min),
                                          longint'(drive_max));
                    last_error = err;
                    prior_meas = meas;
                    last_time  = now;
                    w.updated  = 1'b1;
                end
            end
            mag = (last_error < 0) ? -last_error : last_error;
            w.in_deadband = (mag < longint'(deadband));
            w.drive = w.in_deadband ? sample_t'(0) : sample_t'(held_drive);
            expected_drives.push_back(w);
        endfunction

        task report_mismatch(string what, longint want, longint got);
            if (mismatches < 50)
            begin
                $display("mismatch: %s expected %0d got %0d", what, want, got);
            end
            mismatches++;
        endtask

        task check_drive(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user);
            drive_word_t w;
            if (expected_drives.size() == 0)
            begin
                report_mismatch("word with none pending, drive", 0, longint'(sample_t'(data)));
                return;
            end
            w = expected_drives.pop_front();
            if (w.drive !== sample_t'(data))
            begin
                report_mismatch("drive", longint'(w.drive), longint'(sample_t'(data)));
            end
            if (w.updated !== user[0])
            begin
                report_mismatch("updated", w.updated, user[0]);
            end
            if (w.in_deadband !== user[1])
            begin
                report_mismatch("in_deadband", w.in_deadband, user[1]);
            end
        endtask

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;   // measurement, time_ms
    logic                    s_tuser;   // command
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;   // drive
    logic [OUT_TUSER_W-1:0]  m_tuser;   // updated, in_deadband
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [DATA_W-1:0]       cfg_data;

    pid_drive_predictor drives = new;
    int                 cycle_count = 0;
    logic               long_hold_req = 1'b0;

    pid_controller_step_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic offer_word(input logic cmd, input sample_t meas, input logic [31:0] now);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {now, meas};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        drives.take_word(cmd, meas, now);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (drives.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apply_settings(input sample_t target, input sample_t kp, input sample_t ki,
                                  input sample_t kd, input sample_t lo, input sample_t hi,
                                  input logic [15:0] period, input logic [15:0] band);
        logic [DATA_W-1:0] values[8];
        values = '{target, kp, ki, kd, lo, hi, period, band};
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= values[i];
            @(posedge clk);
            drives.write_reg(CFG_IDX_W'(i), values[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic sample_t pick_gain();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick < 4)
        begin
            return sample_t'(int'($urandom_range(0, 1024)) - 512);
        end
        if (pick < 6)
        begin
            return sample_t'($urandom);
        end
        if (pick == 6)
        begin
            return '0;
        end
        return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    endfunction

    initial
    begin
        int      mode;
        int      mode_left;
        int      hold_left;
        logic    hold_done;
        mode      = 0;
        mode_left = 50;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                drives.check_drive(m_tdata, m_tuser);
            end
            if (long_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 99) < 85);
                    default: m_tready <= ($urandom_range(0, 99) < 25);
                endcase
            end
        end
    end

    initial
    begin
        sample_t     target;
        sample_t     lo;
        sample_t     hi;
        sample_t     meas;
        logic [15:0] period;
        logic [15:0] band;
        logic [31:0] now;
        logic        cmd;
        int          burst_left;
        int          gap;
        int          pick;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_word(1'b0, 16'sd0, 32'd0);
        offer_word(1'b0, 16'sh7fff, 32'd100);
        settle();
        apply_settings(16'sd1000, 16'sd256, 16'sd16, 16'sd64, 16'sh8000, 16'sh7fff,
                       16'd100, 16'd0);
        offer_word(1'b0, 16'sh8000, 32'd200);
        offer_word(1'b0, 16'sh8000, 32'd250);
        offer_word(1'b0, 16'sd1000, 32'd299);
        offer_word(1'b0, 16'sd500, 32'd300);
        offer_word(1'b1, 16'sh7fff, 32'hffff_ffff);
        offer_word(1'b0, 16'sd0, 32'hffff_ffff);
        offer_word(1'b0, 16'sd20, 32'h0000_0062);
        offer_word(1'b0, 16'sd20, 32'h0000_0063);
        settle();
        apply_settings(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sd100, -16'sd100,
                       16'd0, 16'hffff);
        offer_word(1'b0, 16'sh7fff, 32'd5);
        offer_word(1'b0, 16'sh8000, 32'd5);
        offer_word(1'b1, 16'sd0, 32'd0);
        offer_word(1'b0, 16'sd0, 32'd0);
        settle();
        apply_settings(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                       16'hffff, 16'd300);
        offer_word(1'b0, 16'sh7fff, 32'd10);
        offer_word(1'b0, 16'sh8000, 32'd65545);
        offer_word(1'b0, 16'sd32700, 32'd65546);
        offer_word(1'b1, 16'sh8000, 32'h8000_0000);
        offer_word(1'b0, 16'sh8000, 32'd200000);
        settle();

        now = $urandom;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick   = $urandom_range(0, 3);
            target = (pick == 0) ? sample_t'($urandom)
                                 : sample_t'(int'($urandom_range(0, 4000)) - 2000);
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                lo = 16'sh8000;
                hi = 16'sh7fff;
            end
            else
            begin
                lo = sample_t'($urandom);
                hi = sample_t'($urandom);
                if ((pick < 8) == (lo > hi))
                begin
                    {lo, hi} = {hi, lo};
                end
            end
            pick   = $urandom_range(0, 9);
            period = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hffff
                                 : 16'($urandom_range(1, 200));
            pick = $urandom_range(0, 9);
            band = (pick < 3) ? 16'd0 : (pick == 3) ? 16'hffff
                              : 16'($urandom_range(0, 2000));
            if (phase == RANDOM_PHASES - 1)
            begin
                band = 16'($urandom);
            end
            apply_settings(target, pick_gain(), pick_gain(), pick_gain(), lo, hi, period, band);
            if (phase == 1)
            begin
                long_hold_req = 1'b1;
            end
            burst_left = $urandom_range(1, 30);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    now = $urandom;
                end
                else
                begin
                    now = now + $urandom_range(0, 2 * int'(period) + 2);
                end
                cmd  = ($urandom_range(0, 99) < 8);
                meas = ($urandom_range(0, 9) < 4) ? sample_t'($urandom)
                       : sample_t'(int'(target) + int'($urandom_range(0, 600)) - 300);
                offer_word(cmd, meas, now);
                burst_left--;
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                    if (gap > 0)
                    begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 30);
                end
            end
            settle();
        end

        repeat (10) @(posedge clk);
        if (drives.mismatches == 0 && drives.pending() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/pidcs_pkg.sv
src/pid_controller_step_unit.sv
src/pidcs_checker.sv
sim/pid_controller_step_unit_test.sv
